@@ rtl/bfh_pkg.sv @@
// Shared types and constants for the four-hash Bloom filter.
package bfh_pkg;

	// Number of independent hash functions and bit tables.
	localparam int unsigned HASH_COUNT = 4;

	// Default number of entries in each bit table (power of two).
	localparam int unsigned DEF_TABLE_BITS = 1048576;

	// Polynomial hash multipliers, one per table.
	localparam logic [7:0] HASH_MULT [HASH_COUNT] = '{8'd191, 8'd31, 8'd67, 8'd131};

	typedef enum logic {
		OP_ADD   = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	// Control group driven to every bit table.
	typedef struct packed {
		logic we;
		logic re;
		logic wdata;
	} ram_ctl_t;

endpackage

@@ rtl/bfh_hash.sv @@
// Running string hashes and the table indexes they produce on the last character.
module bfh_hash #(
	parameter int unsigned IDX_W = 20
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic signed [7:0] char_value,
	input  logic              last,
	output logic [IDX_W-1:0]  idx_s1 [bfh_pkg::HASH_COUNT]
);
	import bfh_pkg::*;

	// Only the low index bits of a hash ever matter, since the table size is a
	// power of two and wrapping arithmetic keeps low bits independent of high.
	localparam int unsigned EXT_W = (IDX_W > 8) ? IDX_W : 8;

	logic [IDX_W-1:0] hash_q  [HASH_COUNT];
	logic [IDX_W-1:0] hash_nx [HASH_COUNT];
	logic [EXT_W-1:0] prod    [HASH_COUNT];
	logic [EXT_W-1:0] char_ext;

	assign char_ext = EXT_W'(char_value);

	always_comb begin
		for (int i = 0; i < HASH_COUNT; i++) begin
			prod[i]    = EXT_W'(hash_q[i]) * EXT_W'(HASH_MULT[i]);
			hash_nx[i] = IDX_W'(prod[i] + char_ext);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HASH_COUNT; i++) begin
				hash_q[i] <= '0;
			end
		end else if (accept) begin
			for (int i = 0; i < HASH_COUNT; i++) begin
				hash_q[i] <= last ? '0 : hash_nx[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && last) begin
			for (int i = 0; i < HASH_COUNT; i++) begin
				idx_s1[i] <= hash_nx[i];
			end
		end
	end

endmodule

@@ rtl/bfh_bit_ram.sv @@
// One-bit-wide synchronous bit table with registered read data.
module bfh_bit_ram #(
	parameter int unsigned IDX_W = 20
) (
	input  logic               clk,
	input  bfh_pkg::ram_ctl_t  ctl,
	input  logic [IDX_W-1:0]   addr,
	output logic               rdata
);
	import bfh_pkg::*;

	logic mem [2**IDX_W];

	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[addr] <= ctl.wdata;
		end
		if (ctl.re) begin
			rdata <= mem[addr];
		end
	end

endmodule

@@ rtl/bloom_filter_four_hash_core.sv @@
// Top level of the four-hash Bloom filter: handshakes, table sequencing and clearing.
// Throughput: one character per cycle while fewer than two query results are outstanding.
// A query passes the index registers, the table read and the output register in turn.
// An add sets its four bits the cycle after its last character; it returns no item.
// Reset: hashes clear at once, then a clearing pass zeroes all four tables
// (one entry per table per cycle) while input stays stalled.
module bloom_filter_four_hash_core #(
	parameter int unsigned TABLE_BITS = bfh_pkg::DEF_TABLE_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  bfh_pkg::op_t      op,
	input  logic signed [7:0] char_value,
	input  logic              last,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              found
);
	import bfh_pkg::*;

	localparam int unsigned IDX_W = $clog2(TABLE_BITS);

	logic                  accept;
	logic                  clr_q;
	logic [IDX_W-1:0]      clr_addr_q;
	logic                  v_s1;
	op_t                   op_s1;
	logic                  q_s1;
	logic                  qv_s2;
	logic                  out_valid_q;
	logic                  found_q;
	logic                  move_s2;
	logic [1:0]            q_cnt;
	logic [IDX_W-1:0]      idx_s1   [HASH_COUNT];
	logic [IDX_W-1:0]      ram_addr [HASH_COUNT];
	logic [HASH_COUNT-1:0] rdata;
	ram_ctl_t              ram_ctl;

	// Queries in flight, including the one waiting at the output. The first
	// stage never stalls, so new input waits once two are outstanding.
	assign q_cnt    = {1'b0, q_s1} + {1'b0, qv_s2} + {1'b0, out_valid_q};
	assign in_stall = clr_q || q_cnt[1];
	assign accept   = in_valid && !in_stall;

	assign q_s1    = v_s1 && (op_s1 == OP_QUERY);
	assign move_s2 = qv_s2 && (!out_valid_q || !out_stall);

	bfh_hash #(
		.IDX_W(IDX_W)
	) u_hash (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.char_value(char_value),
		.last      (last),
		.idx_s1    (idx_s1)
	);

	always_comb begin
		ram_ctl.we    = clr_q || (v_s1 && (op_s1 == OP_ADD));
		ram_ctl.re    = q_s1;
		ram_ctl.wdata = !clr_q;
		for (int i = 0; i < HASH_COUNT; i++) begin
			ram_addr[i] = clr_q ? clr_addr_q : idx_s1[i];
		end
	end

	for (genvar g = 0; g < HASH_COUNT; g++) begin : g_tab
		bfh_bit_ram #(
			.IDX_W(IDX_W)
		) u_ram (
			.clk  (clk),
			.ctl  (ram_ctl),
			.addr (ram_addr[g]),
			.rdata(rdata[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (&clr_addr_q) begin
				clr_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && last) begin
			op_s1 <= op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			qv_s2       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= accept && last;
			if (q_s1) begin
				qv_s2 <= 1'b1;
			end else if (move_s2) begin
				qv_s2 <= 1'b0;
			end
			if (move_s2) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move_s2) begin
			found_q <= &rdata;
		end
	end

	assign out_valid = out_valid_q;
	assign found     = found_q;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_s1 && qv_s2 && out_valid_q))
		else $error("more than two queries in flight");

	a_s2_held: assert property (@(posedge clk) disable iff (!arst_n)
		qv_s2 && out_valid_q && out_stall |=> qv_s2 && $stable(rdata))
		else $error("waiting query result lost its table data");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(qv_s2))
		else $error("result presented without a query read");

	a_clr_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !v_s1 && !qv_s2)
		else $error("item in flight during table clearing");
`endif

endmodule

@@ dv/bloom_filter_checker.sv @@
// Checker for the four-hash Bloom filter: predicts membership answers and compares them.
`timescale 1ns / 1ps
module bloom_filter_checker #(
	parameter int unsigned TABLE_BITS = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  bfh_pkg::op_t      op,
	input  logic signed [7:0] char_value,
	input  logic              last,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic              found,
	output int                mismatches,
	output int                pending,
	output int                add_count,
	output int                query_count,
	output int                member_count
);
	import bfh_pkg::*;

	localparam int MAX_REPORTS = 10;
	localparam logic [63:0] MULTIPLIER [4] = '{64'd191, 64'd31, 64'd67, 64'd131};

	logic [63:0] running_hash [4];
	bit          member_bits [4][TABLE_BITS];
	bit          expected_found [$];

	function void note_mismatch(string msg);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("[%0t] %s", $realtime, msg);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [63:0] sign_ext;
		logic [63:0] next_hash [4];
		logic [63:0] slot;
		bit          want;
		bit          all_set;
		if (!arst_n) begin
			foreach (running_hash[k])
				running_hash[k] = '0;
			foreach (member_bits[k, j])
				member_bits[k][j] = 1'b0;
			expected_found.delete();
			mismatches = 0;
			add_count = 0;
			query_count = 0;
			member_count = 0;
			pending <= 0;
		end else begin
			// Results are checked before new items so that an answer can never
			// match a query taken at the same edge.
			if (out_valid && !out_stall) begin
				if (expected_found.size() == 0) begin
					note_mismatch($sformatf("unexpected result: found=%b, no query outstanding",
						found));
				end else begin
					want = expected_found.pop_front();
					if (found !== want)
						note_mismatch($sformatf("found mismatch: expected %0b, got %b",
							want, found));
				end
			end
			if (in_valid && !in_stall) begin
				sign_ext = {{56{char_value[7]}}, char_value};
				foreach (next_hash[k])
					next_hash[k] = running_hash[k] * MULTIPLIER[k] + sign_ext;
				if (last) begin
					all_set = 1'b1;
					foreach (next_hash[k]) begin
						slot = next_hash[k] % TABLE_BITS;
						if (op == OP_ADD)
							member_bits[k][slot] = 1'b1;
						else
							all_set &= member_bits[k][slot];
					end
					if (op == OP_ADD) begin
						add_count++;
					end else begin
						expected_found.push_back(all_set);
						query_count++;
						if (all_set)
							member_count++;
					end
					foreach (running_hash[k])
						running_hash[k] = '0;
				end else begin
					running_hash = next_hash;
				end
			end
			pending <= expected_found.size();
		end
	end

endmodule

@@ dv/tb_bloom_filter_four_hash_core.sv @@
// Testbench top for the four-hash Bloom filter: stimulus, pacing and verdict.
`timescale 1ns / 1ps
module tb_bloom_filter_four_hash_core;
	import bfh_pkg::*;

	// A small table keeps the clearing pass short and makes false positives common.
	localparam int unsigned TABLE_BITS = 1024;
	localparam int MAX_LEN = 8;
	localparam int SAVE_DEPTH = 64;
	localparam int RANDOM_CHARS = 426;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	op_t               op = OP_ADD;
	logic signed [7:0] char_value = '0;
	logic              last = 1'b0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic              found;

	int mismatches;
	int pending;
	int add_count;
	int query_count;
	int member_count;

	int send_idle = 0;
	int recv_stall = 0;
	int char_total = 0;
	int word_total = 0;

	logic signed [7:0] word [MAX_LEN];
	int                word_len;
	logic signed [7:0] saved_word [SAVE_DEPTH][MAX_LEN];
	int                saved_len [SAVE_DEPTH];
	int                saved_count = 0;

	always #4 clk = ~clk;

	bloom_filter_four_hash_core #(
		.TABLE_BITS(TABLE_BITS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.char_value(char_value),
		.last      (last),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.found     (found)
	);

	bloom_filter_checker #(
		.TABLE_BITS(TABLE_BITS)
	) membership_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.op          (op),
		.char_value  (char_value),
		.last        (last),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.found       (found),
		.mismatches  (mismatches),
		.pending     (pending),
		.add_count   (add_count),
		.query_count (query_count),
		.member_count(member_count)
	);

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall);
	end

	task automatic send_char(input op_t o, input logic signed [7:0] c, input logic l);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		char_value <= c;
		last <= l;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		char_total++;
	endtask

	// Only the op on the final character counts; the others get early_op.
	task automatic send_word(input op_t final_op, input op_t early_op);
		int save_idx;
		for (int i = 0; i < word_len; i++)
			send_char((i == word_len - 1) ? final_op : early_op, word[i], i == word_len - 1);
		word_total++;
		if (final_op == OP_ADD) begin
			if (saved_count < SAVE_DEPTH) begin
				save_idx = saved_count;
				saved_count++;
			end else begin
				save_idx = $urandom_range(SAVE_DEPTH - 1);
			end
			saved_len[save_idx] = word_len;
			for (int i = 0; i < MAX_LEN; i++)
				saved_word[save_idx][i] = word[i];
		end
	endtask

	task automatic load_word(input int n, input logic signed [7:0] c0,
			input logic signed [7:0] c1 = 0, input logic signed [7:0] c2 = 0,
			input logic signed [7:0] c3 = 0);
		word_len = n;
		word[0] = c0;
		word[1] = c1;
		word[2] = c2;
		word[3] = c3;
	endtask

	// Holds the sender back until every outstanding query has been answered.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	initial begin
		int phase_chars;
		int pick;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		send_idle = 16;
		recv_stall = 82;
		// Single characters: add the two extremes and ask for them back, then query 0 and -1.
		load_word(1, -128);
		send_word(OP_ADD, OP_ADD);
		send_word(OP_QUERY, OP_QUERY);
		load_word(1, 127);
		send_word(OP_ADD, OP_ADD);
		send_word(OP_QUERY, OP_QUERY);
		load_word(1, 0);
		send_word(OP_QUERY, OP_QUERY);
		load_word(1, -1);
		send_word(OP_QUERY, OP_QUERY);
		// The op on earlier characters is opposite to the final one and must be ignored.
		load_word(2, -1, 5);
		send_word(OP_ADD, OP_QUERY);
		send_word(OP_QUERY, OP_ADD);
		load_word(2, 5, -1);
		send_word(OP_QUERY, OP_ADD);
		// Negative characters wrap the 64-bit hashes at once.
		load_word(4, -128, 127, -128, 127);
		send_word(OP_ADD, OP_QUERY);
		send_word(OP_QUERY, OP_ADD);
		load_word(2, -128, 127);
		send_word(OP_QUERY, OP_ADD);
		load_word(1, -128);
		send_word(OP_ADD, OP_QUERY);

		for (int phase = 0; phase < 3; phase++) begin
			drain();
			send_idle = (phase == 0) ? 16 : (phase == 1) ? 82 : 0;
			recv_stall = (phase == 0) ? 82 : (phase == 1) ? 16 : 0;
			phase_chars = 0;
			while (phase_chars < RANDOM_CHARS / 3) begin
				if (saved_count != 0 && $urandom_range(99) < 45) begin
					pick = $urandom_range(saved_count - 1);
					word_len = saved_len[pick];
					for (int i = 0; i < MAX_LEN; i++)
						word[i] = saved_word[pick][i];
				end else begin
					word_len = $urandom_range(MAX_LEN, 1);
					for (int i = 0; i < MAX_LEN; i++)
						word[i] = 8'($urandom_range(255));
				end
				phase_chars += word_len;
				send_word(($urandom_range(99) < 60) ? OP_QUERY : OP_ADD,
					op_t'($urandom_range(1)));
			end
		end

		drain();
		repeat (10) @(posedge clk);
		$display("Run covered %0d characters in %0d strings: %0d adds, %0d queries, %0d hits.",
			char_total, word_total, add_count, query_count, member_count);
		$display("Pacing went from heavy output stall to heavy input gaps to none, %0d-bit tables.",
			TABLE_BITS);
		if (mismatches == 0 && pending == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#1_600_000;
		$display("Run stopped at the time limit with %0d answers outstanding.", pending);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
